// ===== hdl/deque_with_half_rotation_defines.svh =====
// ---------------------------------------------------------------------------
// deque_with_half_rotation_defines
// assertion macros shared by the deque rtl, empty bodies for synthesis
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_HALF_ROTATION_DEFINES_SVH
`define DEQUE_WITH_HALF_ROTATION_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define DQHR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define DQHR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DQHR_ASSERT_IMP(lbl, ante, cons)
`define DQHR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/dqhr_pkg.sv =====
// ---------------------------------------------------------------------------
// dqhr_pkg
// types and codes of the deque with half rotation
// ---------------------------------------------------------------------------
package dqhr_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 1024;

  // command codes
  localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [2:0] CMD_SWAP      = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
  } out_t;

endpackage

// ===== hdl/deque_with_half_rotation.sv =====
// ---------------------------------------------------------------------------
// deque_with_half_rotation
// double-ended queue of signed words in a ring ram with head and count,
// plus a swap-halves command that rotates the contents left by count/2
// ---------------------------------------------------------------------------
//
//  channel | signals                            | moves
//  --------+------------------------------------+----------------------------
//  in      | in_valid, in_stall, in_data        | one command per transfer
//  out     | out_valid, out_stall, out_data     | pop value or status
//
//  push: ram write at the accepting edge
//  pop: ram read register, then the output register; empty or full status:
//    the output register; both wait while out_stall holds the previous result
//  swap: one ram entry copied per cycle through the single read and single
//    write port, floor(count/2) entries in all; a pointer move only when the
//    ring is full, and no change when it holds fewer than two items
//  reset (rst_n low, synchronous) empties the queue; no clearing pass, ram
//    contents are only read inside the occupied window
//
module deque_with_half_rotation #(
  parameter int CAPACITY = dqhr_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dqhr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dqhr_pkg::out_t out_data
);

`include "deque_with_half_rotation_defines.svh"

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_RESP,
    ST_ROT
  } state_t;

  // add an offset to a ring slot, wrap once (both terms stay below the capacity)
  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + SUM_W'(b);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] mod_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  // control state
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  // swap copy pointers: source slot, destination slot, step and length
  logic [IDX_W-1:0]    rot_rd_r, rot_rd_nxt;
  logic [IDX_W-1:0]    rot_wr_r, rot_wr_nxt;
  logic [CNT_W-1:0]    rot_j_r, rot_j_nxt;
  logic [CNT_W-1:0]    rot_k_r, rot_k_nxt;
  logic [1:0]          resp_status_r, resp_status_nxt;
  // output register
  logic                out_valid_r, out_valid_nxt;
  dqhr_pkg::out_t      out_data_r, out_data_nxt;

  // ram port
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [dqhr_pkg::DATA_W-1:0] wr_data;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [dqhr_pkg::DATA_W-1:0] rd_data;

  logic in_fire;
  logic out_free;
  logic full;
  logic empty;

  dqhr_ram #(
    .WIDTH (dqhr_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // one command in flight at a time
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    cnt_nxt         = cnt_r;
    rot_rd_nxt      = rot_rd_r;
    rot_wr_nxt      = rot_wr_r;
    rot_j_nxt       = rot_j_r;
    rot_k_nxt       = rot_k_r;
    resp_status_nxt = resp_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    wr_en           = 1'b0;
    wr_addr         = head_r;
    wr_data         = in_data.push_value;
    rd_en           = 1'b0;
    rd_addr         = head_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.cmd)
            dqhr_pkg::CMD_PUSH_HEAD: begin
              if (full) begin
                resp_status_nxt = dqhr_pkg::ST_FULL;
                state_nxt       = ST_RESP;
              end else begin
                // head moves back one slot, new word lands there
                head_nxt = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - IDX_W'(1);
                wr_en    = 1'b1;
                wr_addr  = head_nxt;
                cnt_nxt  = cnt_r + CNT_W'(1);
              end
            end
            dqhr_pkg::CMD_PUSH_TAIL: begin
              if (full) begin
                resp_status_nxt = dqhr_pkg::ST_FULL;
                state_nxt       = ST_RESP;
              end else begin
                wr_en   = 1'b1;
                wr_addr = mod_add(head_r, cnt_r);
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            dqhr_pkg::CMD_POP_HEAD: begin
              if (empty) begin
                resp_status_nxt = dqhr_pkg::ST_EMPTY;
                state_nxt       = ST_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                head_nxt  = mod_inc(head_r);
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = ST_POP;
              end
            end
            dqhr_pkg::CMD_POP_TAIL: begin
              if (empty) begin
                resp_status_nxt = dqhr_pkg::ST_EMPTY;
                state_nxt       = ST_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = mod_add(head_r, cnt_r - CNT_W'(1));
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = ST_POP;
              end
            end
            dqhr_pkg::CMD_SWAP: begin
              if (cnt_r >= CNT_W'(2)) begin
                if (full) begin
                  // whole ring occupied: rotation is a pointer move
                  head_nxt = mod_add(head_r, cnt_r >> 1);
                end else begin
                  // copy the first count/2 words behind the tail, then
                  // advance head past them; first source read starts now
                  rd_en      = 1'b1;
                  rd_addr    = head_r;
                  rot_rd_nxt = mod_inc(head_r);
                  rot_wr_nxt = mod_add(head_r, cnt_r);
                  rot_j_nxt  = '0;
                  rot_k_nxt  = cnt_r >> 1;
                  state_nxt  = ST_ROT;
                end
              end
            end
            default: begin
              // unused codes are dropped
            end
          endcase
        end
      end

      ST_POP: begin
        // ram data holds until the next read, so waiting here is safe
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.pop_value = $signed(rd_data);
          out_data_nxt.status    = dqhr_pkg::ST_OK;
          state_nxt              = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.pop_value = '0;
          out_data_nxt.status    = resp_status_r;
          state_nxt              = ST_IDLE;
        end
      end

      ST_ROT: begin
        // write back the word read last cycle; the next source slot never
        // equals the slot written now, and earlier writes only land on
        // sources already read
        wr_en      = 1'b1;
        wr_addr    = rot_wr_r;
        wr_data    = rd_data;
        rot_wr_nxt = mod_inc(rot_wr_r);
        if (rot_j_r + CNT_W'(1) == rot_k_r) begin
          head_nxt  = mod_add(head_r, rot_k_r);
          state_nxt = ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = rot_rd_r;
          rot_rd_nxt = mod_inc(rot_rd_r);
          rot_j_nxt  = rot_j_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload and working registers, no reset needed
    rot_rd_r      <= rot_rd_nxt;
    rot_wr_r      <= rot_wr_nxt;
    rot_j_r       <= rot_j_nxt;
    rot_k_r       <= rot_k_nxt;
    resp_status_r <= resp_status_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count never runs past the ring size
  `DQHR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  // a tail push that is not refused grows the queue by one
  `DQHR_ASSERT_NXT(a_push_grows, in_fire && in_data.cmd == dqhr_pkg::CMD_PUSH_TAIL && !full, cnt_r == $past(cnt_r) + CNT_W'(1))
  // the swap copy never changes the item count
  `DQHR_ASSERT_NXT(a_rot_cnt, state_r == ST_ROT, $stable(cnt_r))
  // the copy step stays inside the first half
  `DQHR_ASSERT_IMP(a_rot_step, state_r == ST_ROT, rot_j_r < rot_k_r)
  // a head pop on a non-empty queue waits for its ram data
  `DQHR_ASSERT_NXT(a_pop_wait, in_fire && in_data.cmd == dqhr_pkg::CMD_POP_HEAD && !empty, state_r == ST_POP)

endmodule

// ===== hdl/dqhr_ram.sv =====
// ---------------------------------------------------------------------------
// dqhr_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module dqhr_ram #(
  parameter int WIDTH = dqhr_pkg::DATA_W,
  parameter int DEPTH = dqhr_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while rd_en is low
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
